// File: rtl/rar_pkg.sv
`default_nettype none

package rar_pkg;

    // Fixed field widths of the streams.
    localparam int FIELD_BITS       = 32;
    localparam int KIND_BITS        = 2;
    localparam int WORD_BITS        = 64;
    localparam int MAG_BITS         = 63;
    localparam int SHIFT_BITS       = 6;
    localparam int IN_TDATA_BITS    = 4 * FIELD_BITS;
    localparam int OUT_TDATA_BITS   = 128;
    localparam int OPERAND_BITS_DEF = 32;

    // Sequencing counts.
    localparam int MUL_STEPS = 3;
    localparam int DIV_STEPS = MAG_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    // Which product the shared multiplier forms.
    typedef enum logic [1:0] {
        SEL_TERM_A,
        SEL_TERM_B,
        SEL_DEN
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_GCD,
        ST_SCALE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     prep;
        logic     gcd_step;
        logic     scale;
        logic     div_step;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic gcd_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/rar_datapath.sv
`default_nettype none

module rar_datapath #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rar_pkg::dp_cmd_t                  cmd,
    output rar_pkg::dp_status_t                    status,
    input  wire rar_pkg::kind_t                    in_kind,
    input  wire logic [rar_pkg::IN_TDATA_BITS-1:0] in_data,
    output logic [rar_pkg::WORD_BITS-1:0]          out_num,
    output logic [rar_pkg::MAG_BITS-1:0]           out_den,
    output logic                                   out_div_zero
);

    import rar_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam logic [OB-1:0] MOST_NEG = {1'b1, {(OB-1){1'b0}}};
    localparam logic signed [OB-1:0] OP_ONE = {{(OB-1){1'b0}}, 1'b1};
    localparam logic signed [OB-1:0] OP_ZERO = '0;

    // Low OB bits as two's complement, most negative value pulled in by one,
    // and optionally a zero denominator read as one.
    function automatic logic signed [OB-1:0] take_op(input logic [FIELD_BITS-1:0] raw,
                                                     input logic zero_is_one);
        logic signed [OB-1:0] v;
        v = raw[OB-1:0];
        if (v == MOST_NEG)
        begin
            v = v + OP_ONE;
        end
        if (zero_is_one && (v == OP_ZERO))
        begin
            v = OP_ONE;
        end
        return v;
    endfunction

    logic signed [OB-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    kind_t                kind_reg;
    logic                 dz_reg;

    logic signed [OB-1:0]   mx, my;
    logic signed [2*OB-1:0] prod;
    logic signed [WORD_BITS-1:0] p_reg;
    mul_sel_t               psel_reg;
    logic                   pv_reg;

    logic signed [WORD_BITS-1:0] num_reg, den_reg;
    logic [WORD_BITS-1:0]        num_mag, den_mag;
    logic                        neg_reg;

    logic [MAG_BITS-1:0]   x_reg, y_reg, g_reg;
    logic [SHIFT_BITS-1:0] k_reg;
    logic [MAG_BITS-1:0]   d_xy, d_yx;

    logic [MAG_BITS-1:0]  qn_reg, qd_reg, rn_reg, rd_reg;
    logic [WORD_BITS-1:0] tn, td, g_ext;
    logic                 ge_n, ge_d;

    logic [WORD_BITS-1:0] res_num_reg;
    logic [MAG_BITS-1:0]  res_den_reg;
    logic                 res_dz_reg;

    logic bn_zero;

    assign bn_zero = (bn_reg == OP_ZERO);

    // Operand capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            an_reg   <= take_op(in_data[FIELD_BITS-1:0], 1'b0);
            ad_reg   <= take_op(in_data[2*FIELD_BITS-1:FIELD_BITS], 1'b1);
            bn_reg   <= take_op(in_data[3*FIELD_BITS-1:2*FIELD_BITS], 1'b0);
            bd_reg   <= take_op(in_data[4*FIELD_BITS-1:3*FIELD_BITS], 1'b1);
            dz_reg   <= (in_kind == KIND_DIV) &&
                        (take_op(in_data[3*FIELD_BITS-1:2*FIELD_BITS], 1'b0) == OP_ZERO);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mx = OP_ZERO;
        my = OP_ZERO;
        case (cmd.mul_sel)
            SEL_TERM_A:
            begin
                mx = an_reg;
                if (kind_reg == KIND_MUL)
                    my = bn_reg;
                else if (kind_reg == KIND_DIV && bn_zero)
                    my = OP_ONE;
                else
                    my = bd_reg;
            end
            SEL_TERM_B:
            begin
                if (kind_reg inside {KIND_ADD, KIND_SUB})
                begin
                    mx = bn_reg;
                    my = ad_reg;
                end
            end
            SEL_DEN:
            begin
                mx = ad_reg;
                if (kind_reg == KIND_DIV)
                    my = bn_zero ? OP_ONE : bn_reg;
                else
                    my = bd_reg;
            end
            default:
            begin
                mx = OP_ZERO;
                my = OP_ZERO;
            end
        endcase
    end

    assign prod = mx * my;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            p_reg    <= WORD_BITS'(prod);
            psel_reg <= cmd.mul_sel;
        end
    end

    // Accumulate the registered product in the following cycle.
    always_ff @(posedge clk)
    begin
        if (pv_reg)
        begin
            case (psel_reg)
                SEL_TERM_A: num_reg <= p_reg;
                SEL_TERM_B: num_reg <= (kind_reg == KIND_SUB) ? num_reg - p_reg
                                                              : num_reg + p_reg;
                SEL_DEN:    den_reg <= p_reg;
                default:    num_reg <= num_reg;
            endcase
        end
    end

    assign num_mag = num_reg[WORD_BITS-1] ? WORD_BITS'(-num_reg) : WORD_BITS'(num_reg);
    assign den_mag = den_reg[WORD_BITS-1] ? WORD_BITS'(-den_reg) : WORD_BITS'(den_reg);

    assign d_xy = x_reg - y_reg;
    assign d_yx = y_reg - x_reg;

    // Binary GCD: one step per cycle, common factors of two counted in k.
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            neg_reg <= num_reg[WORD_BITS-1] ^ den_reg[WORD_BITS-1];
            x_reg   <= num_mag[MAG_BITS-1:0];
            y_reg   <= den_mag[MAG_BITS-1:0];
            qn_reg  <= num_mag[MAG_BITS-1:0];
            qd_reg  <= den_mag[MAG_BITS-1:0];
            k_reg   <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + SHIFT_BITS'(1);
            end
            else if (!x_reg[0])
            begin
                x_reg <= x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_reg <= y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_reg <= d_xy >> 1;
            end
            else
            begin
                y_reg <= d_yx >> 1;
            end
        end
        else if (cmd.div_step)
        begin
            qn_reg <= {qn_reg[MAG_BITS-2:0], ge_n};
            qd_reg <= {qd_reg[MAG_BITS-2:0], ge_d};
        end
    end

    assign status.gcd_done = (x_reg == '0);

    // Restoring division of both magnitudes by the common divisor.
    assign g_ext = {1'b0, g_reg};
    assign tn    = {rn_reg, qn_reg[MAG_BITS-1]};
    assign td    = {rd_reg, qd_reg[MAG_BITS-1]};
    assign ge_n  = (tn >= g_ext);
    assign ge_d  = (td >= g_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            g_reg  <= y_reg << k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rn_reg <= ge_n ? MAG_BITS'(tn - g_ext) : tn[MAG_BITS-1:0];
            rd_reg <= ge_d ? MAG_BITS'(td - g_ext) : td[MAG_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_num_reg <= neg_reg ? WORD_BITS'(-{1'b0, qn_reg}) : {1'b0, qn_reg};
            res_den_reg <= qd_reg;
            res_dz_reg  <= dz_reg;
        end
    end

    assign out_num      = res_num_reg;
    assign out_den      = res_den_reg;
    assign out_div_zero = res_dz_reg;

endmodule

`default_nettype wire

// File: rtl/rar_ctrl.sv
`default_nettype none

module rar_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rar_pkg::dp_cmd_t         cmd,
    input  wire rar_pkg::dp_status_t status
);

    import rar_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_BITS'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_SUM:   state_next = ST_PREP;
            ST_PREP:  state_next = ST_GCD;
            ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end
            ST_OUT:
            begin
                if (!valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = mul_sel_t'(cnt_reg[1:0]);
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:   cmd.mul_en   = 1'b1;
            ST_SUM:   cmd.mul_en   = 1'b0;
            ST_PREP:  cmd.prep     = 1'b1;
            ST_GCD:   cmd.gcd_step = !status.gcd_done;
            ST_SCALE: cmd.scale    = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_OUT:   cmd.out_load = !valid_reg || out_ready;
            default:  in_ready     = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// File: rtl/rational_arith_reduce_unit.sv
// Exact arithmetic on two signed fractions with the result in lowest terms.
// The slave stream carries one operation per transfer: tuser selects add,
// subtract, multiply or divide, and tdata holds a_num, a_den, b_num, b_den.
// Only the low OPERAND_BITS of each operand count; a zero denominator is
// read as one. The master stream returns the reduced numerator and a
// positive denominator in tdata, and tuser flags a divide by a zero fraction,
// in which case the first operand comes back reduced.
// One item is worked at a time. After the input transfer the shared
// multiplier forms three products, the SUM and PREP states finish the sum
// and take magnitudes, a binary GCD loop runs one step a cycle, and a
// one-bit-per-cycle divider scales numerator and denominator by the GCD.
// The GCD loop and the serial divider set the rate.
// The finished result sits in an output register, so a new item is taken
// while the receiver stalls; the next result then waits until that one is
// taken. Reset clears the controller and the output valid, and the block is
// ready for an input transfer in the first cycle after reset.
`default_nettype none

module rational_arith_reduce_unit #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // a_num, a_den, b_num, b_den, 32 bits each, from the lowest bit up.
    input  wire logic [rar_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // kind: 0 add, 1 subtract, 2 multiply, 3 divide.
    input  wire logic [rar_pkg::KIND_BITS-1:0]      s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // res_num (64 bits), res_den (63 bits), one zero pad bit.
    output logic [rar_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata,
    // div_zero.
    output logic [0:0]                              m_axis_tuser
);

    import rar_pkg::*;

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic [WORD_BITS-1:0] res_num;
    logic [MAG_BITS-1:0]  res_den;
    logic                 div_zero;

    // Sequencer: walks multiply, sum, prepare, GCD, scale, divide and output phases.
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // Operand registers, shared multiplier, GCD and divider, result register.
    rar_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_kind      (kind_t'(s_axis_tuser)),
        .in_data      (s_axis_tdata),
        .out_num      (res_num),
        .out_den      (res_den),
        .out_div_zero (div_zero)
    );

    assign m_axis_tdata = {1'b0, res_den, res_num};
    assign m_axis_tuser = div_zero;

endmodule

`default_nettype wire

// File: verif/rational_arith_reduce_unit_tb.sv
`default_nettype none

module rational_arith_reduce_unit_tb;

    import rar_pkg::*;

    // The block is built with its default operand width; the predictor follows it.
    localparam int OPERAND_BITS = OPERAND_BITS_DEF;

    // Number of random operations after the directed table.
    localparam int RANDOM_OPS = 1900;

    // The cycle limit lies well above what a correct run needs, stalls and gaps included.
    localparam int CYCLE_LIMIT = 2_500_000;

    // Cycles allowed after the last result. This covers the longest reduction.
    localparam int DRAIN_CYCLES = 300;

    // One reduced fraction as the master stream returns it.
    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        div_zero;
    } frac_result_t;

    // One row of the directed table. Where has_fixed is set, the expected fraction is
    // typed in. Otherwise the predictor supplies it.
    typedef struct {
        kind_t       kind;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
        bit          has_fixed;
        logic [63:0] e_num;
        logic [62:0] e_den;
        bit          e_div_zero;
    } op_row_t;

    localparam int DIRECTED_OPS = 24;

    op_row_t directed_ops [DIRECTED_OPS] = '{
        // Plain cases of each operation.
        '{KIND_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 1'b1, 64'sd5, 63'd6, 1'b0},
        '{KIND_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 1'b1, 64'sd1, 63'd6, 1'b0},
        '{KIND_MUL, 32'sd2, 32'sd3, 32'sd3, 32'sd4, 1'b1, 64'sd1, 63'd2, 1'b0},
        '{KIND_DIV, 32'sd1, 32'sd2, 32'sd1, 32'sd4, 1'b1, 64'sd2, 63'd1, 1'b0},
        // Division by a zero fraction. The first operand comes back reduced with a
        // positive denominator.
        '{KIND_DIV, 32'sd6, 32'sd4, 32'sd0, 32'sd5, 1'b1, 64'sd3, 63'd2, 1'b1},
        '{KIND_DIV, 32'sd6, -32'sd4, 32'sd0, 32'sd1, 1'b1, -64'sd3, 63'd2, 1'b1},
        '{KIND_DIV, 32'sd0, 32'sd5, 32'sd0, 32'sd3, 1'b1, 64'sd0, 63'd1, 1'b1},
        '{KIND_DIV, 32'sd5, 32'sd1, 32'sd0, 32'sd0, 1'b1, 64'sd5, 63'd1, 1'b1},
        // A zero result gives 0/1.
        '{KIND_ADD, 32'sd1, 32'sd2, -32'sd1, 32'sd2, 1'b1, 64'sd0, 63'd1, 1'b0},
        '{KIND_MUL, 32'sd0, 32'sd7, 32'sd5, 32'sd3, 1'b1, 64'sd0, 63'd1, 1'b0},
        '{KIND_SUB, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 64'sd0, 63'd1, 1'b0},
        // A zero denominator is read as one.
        '{KIND_ADD, 32'sd3, 32'sd0, 32'sd0, 32'sd0, 1'b1, 64'sd3, 63'd1, 1'b0},
        // The most negative operand saturates to one above it.
        '{KIND_MUL, 32'h8000_0000, 32'sd1, 32'sd1, 32'sd1, 1'b1,
          -64'sd2147483647, 63'd1, 1'b0},
        '{KIND_ADD, 32'sd1, 32'h8000_0000, 32'sd1, 32'h8000_0000, 1'b1,
          -64'sd2, 63'd2147483647, 1'b0},
        // Largest magnitudes.
        '{KIND_ADD, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1, 1'b1,
          64'sd4294967294, 63'd1, 1'b0},
        '{KIND_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
          64'sd1, 63'd1, 1'b0},
        '{KIND_MUL, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1, 1'b0,
          64'd0, 63'd0, 1'b0},
        '{KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001, 1'b0,
          64'd0, 63'd0, 1'b0},
        '{KIND_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0001, 32'h7fff_ffff, 1'b0,
          64'd0, 63'd0, 1'b0},
        '{KIND_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0,
          64'd0, 63'd0, 1'b0},
        // Signs and long reductions.
        '{KIND_DIV, -32'sd3, 32'sd7, -32'sd9, 32'sd14, 1'b0, 64'd0, 63'd0, 1'b0},
        '{KIND_SUB, 32'sd2147483647, 32'sd2147483629, 32'sd2147483629, 32'sd2147483647,
          1'b0, 64'd0, 63'd0, 1'b0},
        '{KIND_MUL, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 1'b0,
          64'd0, 63'd0, 1'b0},
        '{KIND_MUL, -32'sd1, -32'sd1, 32'sd0, -32'sd1, 1'b0, 64'd0, 63'd0, 1'b0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic [KIND_BITS-1:0]      s_axis_tuser = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic [0:0]                m_axis_tuser;

    // Expected fractions, oldest first. An entry is added when the input transfer is
    // accepted and removed when its result transfer is accepted.
    frac_result_t pending_fracs [$];

    int  error_count = 0;
    int  ops_sent = 0;
    int  results_seen = 0;
    int  div_zero_seen = 0;
    int  kind_count [4] = '{0, 0, 0, 0};
    int  cycle_count = 0;
    int  ready_hold = 0;
    bit  ready_free = 1'b0;

    rational_arith_reduce_unit #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The clock has a period of 8 time units.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // This function takes the low OPERAND_BITS of a field as a two's complement value.
    // The most negative value is pulled up by one, so the products stay exact.
    function automatic longint take_field(logic [31:0] raw);
        longint top;
        longint v;
        top = longint'(1) << (OPERAND_BITS - 1);
        v = longint'(raw) & ((longint'(1) << OPERAND_BITS) - 1);
        if (v >= top)
            v = v - (top << 1);
        if (v == -top)
            v = v + 1;
        return v;
    endfunction

    // This function computes the exact result of one operation, reduced to lowest
    // terms with a positive denominator.
    function automatic frac_result_t rational_result(kind_t kind, logic [31:0] a_num_raw,
                                                     logic [31:0] a_den_raw,
                                                     logic [31:0] b_num_raw,
                                                     logic [31:0] b_den_raw);
        frac_result_t res;
        longint an;
        longint ad;
        longint bn;
        longint bd;
        longint num;
        longint den;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned x;
        longint unsigned y;
        longint unsigned r;
        bit neg;
        an = take_field(a_num_raw);
        ad = take_field(a_den_raw);
        bn = take_field(b_num_raw);
        bd = take_field(b_den_raw);
        if (ad == 0)
            ad = 1;
        if (bd == 0)
            bd = 1;
        res.div_zero = 1'b0;
        case (kind)
            KIND_ADD:
            begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            KIND_SUB:
            begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            KIND_MUL:
            begin
                num = an * bn;
                den = ad * bd;
            end
            default:
            begin
                if (bn == 0)
                begin
                    res.div_zero = 1'b1;
                    num = an;
                    den = ad;
                end
                else
                begin
                    num = an * bd;
                    den = ad * bn;
                end
            end
        endcase
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        neg = (num < 0);
        un = neg ? longint'(-num) : num;
        ud = den;
        // This is Euclid's algorithm on the magnitudes.
        x = un;
        y = ud;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x == 0)
            x = 1;
        un = un / x;
        ud = ud / x;
        res.num = neg ? (64'd0 - un) : un;
        res.den = ud[62:0];
        return res;
    endfunction

    // This function returns one of the boundary values of a 32-bit operand.
    function automatic logic [31:0] edge_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hffff_ffff;
            3:       return 32'h7fff_ffff;
            4:       return 32'h8000_0000;
            5:       return 32'h8000_0001;
            6:       return 32'h7fff_fffe;
            default: return 32'h0000_0002;
        endcase
    endfunction

    // This task offers one operation on the slave stream and holds it until the
    // transfer happens. It starts and ends on a falling edge. The expected fraction
    // is queued at the accepting edge.
    task automatic send_op(kind_t kind, logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                           logic [31:0] bd, bit has_fixed, frac_result_t fixed_res);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bd, bn, ad, an};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (has_fixed)
            pending_fracs.push_back(fixed_res);
        else
            pending_fracs.push_back(rational_result(kind, an, ad, bn, bd));
        ops_sent++;
        kind_count[kind]++;
        @(negedge clk);
    endtask

    // The receiver keeps tready at one level for a random hold. It is mostly ready.
    // Some holds are long stalls. While ready_free is set, it never stalls.
    always @(negedge clk)
    begin
        if (ready_free)
            m_axis_tready <= 1'b1;
        else if (ready_hold == 0)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                m_axis_tready <= 1'b1;
                ready_hold <= $urandom_range(0, 40);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 8);
            end
        end
        else
            ready_hold <= ready_hold - 1;
    end

    // Each result transfer is checked field by field against the oldest expected
    // fraction.
    always @(posedge clk)
    begin : result_check
        frac_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_fracs.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, got %0d/%0d dz=%0d",
                         $time, $signed(m_axis_tdata[63:0]), m_axis_tdata[126:64],
                         m_axis_tuser[0]);
                error_count++;
            end
            else
            begin
                want = pending_fracs.pop_front();
                results_seen++;
                if (m_axis_tuser[0])
                    div_zero_seen++;
                if (m_axis_tdata[63:0] !== want.num)
                begin
                    $display("%0t: res_num mismatch, expected %0d, actual %0d", $time,
                             $signed(want.num), $signed(m_axis_tdata[63:0]));
                    error_count++;
                end
                if (m_axis_tdata[126:64] !== want.den)
                begin
                    $display("%0t: res_den mismatch, expected %0d, actual %0d", $time,
                             want.den, m_axis_tdata[126:64]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.div_zero)
                begin
                    $display("%0t: div_zero mismatch, expected %0d, actual %0d", $time,
                             want.div_zero, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // The watchdog ends a run that hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results still expected", $time,
                 cycle_count, pending_fracs.size());
        $display("** rational_arith_reduce_unit: FAILED **");
        $finish;
    end

    initial
    begin
        frac_result_t fixed_res;
        frac_result_t no_res;
        kind_t        kind;
        logic [31:0]  an;
        logic [31:0]  ad;
        logic [31:0]  bn;
        logic [31:0]  bd;
        int           burst;
        int           gap;
        int           mode;
        int           factor;
        int           sent_random;
        bit           drained_once;

        no_res = '{64'd0, 63'd0, 1'b0};
        sent_random = 0;
        drained_once = 1'b0;

        // Reset is held low at the start and released on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // In the directed part, the rows go out one after another with short random
        // gaps while the receiver stalls at random.
        foreach (directed_ops[i])
        begin
            fixed_res = '{directed_ops[i].e_num, directed_ops[i].e_den,
                          directed_ops[i].e_div_zero};
            send_op(directed_ops[i].kind, directed_ops[i].a_num, directed_ops[i].a_den,
                    directed_ops[i].b_num, directed_ops[i].b_den,
                    directed_ops[i].has_fixed, fixed_res);
            gap = $urandom_range(0, 3);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end

        // The random part runs in bursts. The first stretch has no gaps and no stalls,
        // so operations follow each other as fast as the block takes them.
        while (sent_random < RANDOM_OPS)
        begin
            ready_free = (sent_random < 150);
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst && sent_random < RANDOM_OPS; j++)
            begin
                kind = kind_t'($urandom_range(0, 3));
                mode = $urandom_range(0, 9);
                case (mode)
                    0, 1, 2, 3:
                    begin
                        // These are full-width random bit patterns.
                        an = $urandom();
                        ad = $urandom();
                        bn = $urandom();
                        bd = $urandom();
                    end
                    4, 5:
                    begin
                        // Small signed values often share factors and hit zero.
                        an = $urandom_range(0, 40) - 20;
                        ad = $urandom_range(0, 40) - 20;
                        bn = $urandom_range(0, 40) - 20;
                        bd = $urandom_range(0, 40) - 20;
                    end
                    6:
                    begin
                        // These are integer operands with a denominator of one.
                        an = ($urandom_range(0, 1) != 0) ? $urandom()
                                                         : $urandom_range(0, 200) - 100;
                        bn = ($urandom_range(0, 1) != 0) ? $urandom()
                                                         : $urandom_range(0, 200) - 100;
                        ad = 32'd1;
                        bd = 32'd1;
                    end
                    7:
                    begin
                        // A common factor on all four operands makes a long reduction.
                        factor = $urandom_range(1, 65535);
                        an = factor * $urandom_range(0, 32767);
                        ad = factor * $urandom_range(1, 32767);
                        bn = factor * $urandom_range(0, 32767);
                        bd = factor * $urandom_range(1, 32767);
                        if ($urandom_range(0, 1) != 0)
                            an = -an;
                        if ($urandom_range(0, 1) != 0)
                            ad = -ad;
                        if ($urandom_range(0, 1) != 0)
                            bn = -bn;
                        if ($urandom_range(0, 1) != 0)
                            bd = -bd;
                    end
                    8:
                    begin
                        an = edge_operand();
                        ad = edge_operand();
                        bn = edge_operand();
                        bd = edge_operand();
                    end
                    default:
                    begin
                        // This is a divide by a zero fraction with random other operands.
                        kind = KIND_DIV;
                        an = $urandom();
                        ad = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
                        bn = 32'd0;
                        bd = $urandom();
                    end
                endcase
                send_op(kind, an, ad, bn, bd, 1'b0, no_res);
                sent_random++;
            end
            if (!drained_once && sent_random >= RANDOM_OPS / 2)
            begin
                // The sender holds off once until every queued result has come back.
                drained_once = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (pending_fracs.size() != 0)
                    @(negedge clk);
            end
            else if (sent_random >= 150)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 250)
                                                  : $urandom_range(0, 30);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end

        // When the stimulus is done, the testbench waits for the results still in
        // flight and then a while longer, so that any extra transfer shows up.
        s_axis_tvalid <= 1'b0;
        while (pending_fracs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d operations (add %0d, sub %0d, mul %0d, div %0d) in %0d cycles.",
                 ops_sent, kind_count[KIND_ADD], kind_count[KIND_SUB],
                 kind_count[KIND_MUL], kind_count[KIND_DIV], cycle_count);
        $display("Checked %0d reduced results, %0d of them divide-by-zero, %0d errors.",
                 results_seen, div_zero_seen, error_count);
        if (error_count == 0)
            $display("** rational_arith_reduce_unit: PASSED **");
        else
            $display("** rational_arith_reduce_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
